// ----- rtl/mse_pkg.sv -----
// shared types for the merge sort engine
`default_nettype none

package mse_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RUN_INIT,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } mse_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_wr;
        logic close;
        logic run_init;
        logic merge_rd;
        logic merge_wr;
        logic next_run;
        logic next_pass;
        logic emit_rd;
        logic emit_next;
    } mse_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic closing;
        logic single;
        logic run_last;
        logic pass_last;
        logic sort_last;
        logic emit_last;
    } mse_status_t;

endpackage

`default_nettype wire

// ----- rtl/mse_in_if.sv -----
// input stream interface: one element per transaction
`default_nettype none

interface mse_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;

    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/mse_out_if.sv -----
// output stream interface: one sorted element per transaction
`default_nettype none

interface mse_out_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] sorted_value;
    logic                         final_res;

    modport source (output valid, sorted_value, final_res, input ready);
    modport sink   (input valid, sorted_value, final_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/mse_ctrl.sv -----
// control state machine for load, merge passes and emission
`default_nettype none

module mse_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire mse_pkg::mse_status_t status,
    output mse_pkg::mse_cmd_t      cmd
);
    import mse_pkg::*;

    mse_state_t state_reg;
    mse_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (status.closing)
                    begin
                        cmd.close = 1'b1;
                        // a one-element set is already sorted
                        state_next = status.single ? ST_EMIT_RD : ST_RUN_INIT;
                    end
                end
            end
            ST_RUN_INIT:
            begin
                cmd.run_init = 1'b1;
                state_next   = ST_MERGE_RD;
            end
            ST_MERGE_RD:
            begin
                cmd.merge_rd = 1'b1;
                state_next   = ST_MERGE_WR;
            end
            ST_MERGE_WR:
            begin
                cmd.merge_wr = 1'b1;
                if (!status.run_last)
                begin
                    state_next = ST_MERGE_RD;
                end
                else if (!status.pass_last)
                begin
                    cmd.next_run = 1'b1;
                    state_next   = ST_RUN_INIT;
                end
                else
                begin
                    cmd.next_pass = 1'b1;
                    state_next    = status.sort_last ? ST_EMIT_RD : ST_RUN_INIT;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.emit_last)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/mse_datapath.sv -----
// element store, merge scratch, run counters and merge compare
`default_nettype none

module mse_datapath #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mse_pkg::mse_cmd_t            cmd,
    output mse_pkg::mse_status_t              status,
    input  wire logic signed [VALUE_BITS-1:0] in_value,
    input  wire logic                         in_last,
    output logic signed [VALUE_BITS-1:0]      out_value
);
    import mse_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 2;

    logic [VALUE_BITS-1:0] mem_a [CAPACITY];
    logic [VALUE_BITS-1:0] mem_b [CAPACITY];

    logic [VALUE_BITS-1:0] a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, lo_reg, mid_reg, hi_reg, a_reg, b_reg, k_reg, e_reg;
    logic [SW-1:0] width_reg;
    logic          sel_reg;

    logic [SW-1:0]         sum_mid, sum_hi, width_dbl;
    logic [CW-1:0]         mid_new, hi_new;
    logic signed [VALUE_BITS-1:0] head_a, head_b, merge_data;
    logic                  take_a;
    logic [CW-1:0]         k_inc, e_inc;
    logic [AW-1:0]         rd0_addr, rd1_addr, wr_addr_a;
    logic                  wr_en_a, wr_en_b, rd_en;
    logic [VALUE_BITS-1:0] wr_data_a;

    // run bounds, clipped to the set size
    assign width_dbl = width_reg << 1;
    assign sum_mid   = SW'(lo_reg) + width_reg;
    assign sum_hi    = SW'(lo_reg) + width_dbl;
    assign mid_new   = (sum_mid > SW'(n_reg)) ? n_reg : sum_mid[CW-1:0];
    assign hi_new    = (sum_hi > SW'(n_reg)) ? n_reg : sum_hi[CW-1:0];

    assign head_a = sel_reg ? b_rd0_q : a_rd0_q;
    assign head_b = sel_reg ? b_rd1_q : a_rd1_q;
    // left run wins ties
    assign take_a = (a_reg < mid_reg) && ((b_reg >= hi_reg) || (head_a <= head_b));
    assign merge_data = take_a ? head_a : head_b;

    assign k_inc = k_reg + CW'(1);
    assign e_inc = e_reg + CW'(1);

    assign status.closing   = in_last || (count_reg == CW'(CAPACITY - 1));
    assign status.single    = (count_reg == '0);
    assign status.run_last  = (k_inc == hi_reg);
    assign status.pass_last = (hi_reg == n_reg);
    assign status.sort_last = width_dbl >= SW'(n_reg);
    assign status.emit_last = (e_inc == n_reg);

    assign rd0_addr  = cmd.merge_rd ? a_reg[AW-1:0] : e_reg[AW-1:0];
    assign rd1_addr  = b_reg[AW-1:0];
    assign rd_en     = cmd.merge_rd || cmd.emit_rd;
    assign wr_en_a   = cmd.load_wr || (cmd.merge_wr && sel_reg);
    assign wr_en_b   = cmd.merge_wr && !sel_reg;
    assign wr_addr_a = cmd.load_wr ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wr_data_a = cmd.load_wr ? in_value : merge_data;

    assign out_value = sel_reg ? b_rd0_q : a_rd0_q;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load_wr)
        begin
            count_next = status.closing ? '0 : count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_a)
        begin
            mem_a[wr_addr_a] <= wr_data_a;
        end
        if (wr_en_b)
        begin
            mem_b[k_reg[AW-1:0]] <= merge_data;
        end
        if (rd_en)
        begin
            a_rd0_q <= mem_a[rd0_addr];
            a_rd1_q <= mem_a[rd1_addr];
            b_rd0_q <= mem_b[rd0_addr];
            b_rd1_q <= mem_b[rd1_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            n_reg     <= '0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            k_reg     <= '0;
            e_reg     <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.close)
            begin
                n_reg     <= count_reg + CW'(1);
                width_reg <= SW'(1);
                lo_reg    <= '0;
                e_reg     <= '0;
                sel_reg   <= 1'b0;
            end
            if (cmd.run_init)
            begin
                mid_reg <= mid_new;
                hi_reg  <= hi_new;
                a_reg   <= lo_reg;
                b_reg   <= mid_new;
                k_reg   <= lo_reg;
            end
            if (cmd.merge_wr)
            begin
                k_reg <= k_inc;
                if (take_a)
                begin
                    a_reg <= a_reg + CW'(1);
                end
                else
                begin
                    b_reg <= b_reg + CW'(1);
                end
            end
            if (cmd.next_run)
            begin
                lo_reg <= hi_reg;
            end
            if (cmd.next_pass)
            begin
                lo_reg    <= '0;
                width_reg <= width_dbl;
                sel_reg   <= !sel_reg;
            end
            if (cmd.emit_next)
            begin
                e_reg <= e_inc;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/merge_sort_engine.sv -----
// merge sort engine top level: batch sorter for signed values
// load: one element per cycle; the element flagged last, or the one that fills the store, closes the set
// sort: bottom-up merge, ceil(log2 n) passes; each run pair is set up, then each element is read and written
// emission: each result is read from the store, then offered until the sink is ready
// one set is handled at a time; input is not taken again until the last result leaves
// reset: asynchronous active-low, returns to loading with an empty set; store contents are undefined
`default_nettype none

module merge_sort_engine #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mse_in_if.sink     items,
    mse_out_if.source  results
);
    import mse_pkg::*;

    mse_cmd_t    cmd;
    mse_status_t status;

    // sequencing: load, merge passes, emit
    mse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // stores, ping-pong merge and run bookkeeping
    mse_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_value  (items.value),
        .in_last   (items.last),
        .out_value (results.sorted_value)
    );

    // the final result of a set is the one whose index is one below the set size
    assign results.final_res = status.emit_last;

    // loading and emission never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(items.ready && results.valid))
        else $error("input ready while a result is offered");

    // a transaction flagged last stops loading
    a_close_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready && items.last) |=> !items.ready)
        else $error("loading continued after the set closed");

    // after the final result the engine is ready for a new set
    a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.final_res) |=> items.ready)
        else $error("engine not ready after the final result");

endmodule

`default_nettype wire
